// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/lsac_pkg.sv =====
package lsac_pkg;

  // field widths
  localparam int GAIN_W    = 24;
  localparam int SPEED_W   = 8;
  localparam int LIMIT_W   = 15;
  localparam int COORD_W   = 16;
  localparam int ANGLE_W   = 17;
  localparam int TURN_W    = 10;

  // fixed point
  localparam int ANGLE_FRAC = 8;
  localparam int GAIN_FRAC  = 20;
  localparam int TABLE_FRAC = 24;
  localparam int GUARD_BITS = 14;
  localparam int SLOPE_FRAC = 12;
  localparam int RND_SH     = TABLE_FRAC - ANGLE_FRAC;
  localparam int TURN_SH    = GAIN_FRAC + ANGLE_FRAC;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TABLE_LEN        = 24;
  localparam int TBL_IDX_W        = 5;

  // datapath widths
  localparam int CORDIC_W = 34;
  localparam int ZACC_W   = 33;
  localparam int TMP_W    = 26;
  localparam int PROD_W   = 51;
  localparam int ACC_W    = 52;

  localparam logic signed [ANGLE_W-1:0] NINETY = ANGLE_W'(90 << ANGLE_FRAC);
  localparam logic signed [TURN_W-1:0]  TURN_MAX = TURN_W'(511);
  localparam logic signed [TURN_W-1:0]  TURN_MIN = TURN_W'(-512);

  // APB register map
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_P      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SPEED       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SLOPE_LIMIT = 3'd4;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [SPEED_W-1:0] vehicle_speed;
    logic [LIMIT_W-1:0] slope_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    gain_p:        GAIN_W'(1048576),
    gain_i:        GAIN_W'(2097),
    gain_d:        GAIN_W'(3146),
    vehicle_speed: SPEED_W'(10),
    slope_limit:   LIMIT_W'(4096)
  };

  typedef struct packed {
    logic                      done;
    logic signed [TURN_W-1:0]  turn_command;
    logic signed [ANGLE_W-1:0] heading_angle;
  } res_t;

  // microcode
  typedef logic [3:0] step_t;
  localparam step_t STEP_IDLE    = 4'd0;
  localparam step_t STEP_PREP    = 4'd1;
  localparam step_t STEP_ITER    = 4'd2;
  localparam step_t STEP_ROUND   = 4'd3;
  localparam step_t STEP_MUL_SPD = 4'd4;
  localparam step_t STEP_MUL_P   = 4'd5;
  localparam step_t STEP_MUL_I   = 4'd6;
  localparam step_t STEP_MUL_D   = 4'd7;
  localparam step_t STEP_ACC     = 4'd8;
  localparam step_t STEP_OUT     = 4'd9;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_PREP, OP_ITER, OP_ROUND,
    OP_MUL_SPD, OP_MUL_P, OP_MUL_I, OP_MUL_D, OP_ACC, OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    CD_NEXT, CD_WAIT_IN, CD_SKIP, CD_LOOP, CD_WAIT_OUT, CD_JUMP
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  function automatic uword_t ucode(input step_t pc);
    uword_t w;
    case (pc)
      STEP_IDLE:    w = '{op: OP_LOAD,    cond: CD_WAIT_IN,  target: STEP_IDLE};
      STEP_PREP:    w = '{op: OP_PREP,    cond: CD_SKIP,     target: STEP_MUL_SPD};
      STEP_ITER:    w = '{op: OP_ITER,    cond: CD_LOOP,     target: STEP_ITER};
      STEP_ROUND:   w = '{op: OP_ROUND,   cond: CD_NEXT,     target: STEP_IDLE};
      STEP_MUL_SPD: w = '{op: OP_MUL_SPD, cond: CD_NEXT,     target: STEP_IDLE};
      STEP_MUL_P:   w = '{op: OP_MUL_P,   cond: CD_NEXT,     target: STEP_IDLE};
      STEP_MUL_I:   w = '{op: OP_MUL_I,   cond: CD_NEXT,     target: STEP_IDLE};
      STEP_MUL_D:   w = '{op: OP_MUL_D,   cond: CD_NEXT,     target: STEP_IDLE};
      STEP_ACC:     w = '{op: OP_ACC,     cond: CD_NEXT,     target: STEP_IDLE};
      STEP_OUT:     w = '{op: OP_OUT,     cond: CD_WAIT_OUT, target: STEP_IDLE};
      default:      w = '{op: OP_NOP,     cond: CD_JUMP,     target: STEP_IDLE};
    endcase
    return w;
  endfunction

  // atan(2^-i) in degrees, Q.24
  function automatic logic signed [ZACC_W-1:0] atan_q24(input logic [TBL_IDX_W-1:0] idx);
    logic signed [ZACC_W-1:0] v;
    case (idx)
      5'd0:  v = ZACC_W'(754974720);
      5'd1:  v = ZACC_W'(445687602);
      5'd2:  v = ZACC_W'(235489088);
      5'd3:  v = ZACC_W'(119537938);
      5'd4:  v = ZACC_W'(60000934);
      5'd5:  v = ZACC_W'(30029717);
      5'd6:  v = ZACC_W'(15018523);
      5'd7:  v = ZACC_W'(7509720);
      5'd8:  v = ZACC_W'(3754917);
      5'd9:  v = ZACC_W'(1877466);
      5'd10: v = ZACC_W'(938734);
      5'd11: v = ZACC_W'(469367);
      5'd12: v = ZACC_W'(234684);
      5'd13: v = ZACC_W'(117342);
      5'd14: v = ZACC_W'(58671);
      5'd15: v = ZACC_W'(29336);
      5'd16: v = ZACC_W'(14668);
      5'd17: v = ZACC_W'(7334);
      5'd18: v = ZACC_W'(3667);
      5'd19: v = ZACC_W'(1834);
      5'd20: v = ZACC_W'(917);
      5'd21: v = ZACC_W'(458);
      5'd22: v = ZACC_W'(229);
      5'd23: v = ZACC_W'(115);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/lsac_engine.sv =====
`include "assert_macros.svh"

module lsac_engine #(
  parameter int CORDIC_STEPS = lsac_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  lsac_pkg::cfg_t                          cfg,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    in_mode,
  input  logic signed [lsac_pkg::COORD_W-1:0]     in_px,
  input  logic signed [lsac_pkg::COORD_W-1:0]     in_py,
  input  logic signed [lsac_pkg::COORD_W-1:0]     in_slope,
  input  logic                                    out_free,
  output lsac_pkg::res_t                          res
);
  import lsac_pkg::*;

  localparam int ITER_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);
  localparam logic signed [CORDIC_W-1:0] SLOPE_ONE_X =
    CORDIC_W'(64'sd1 << (SLOPE_FRAC + GUARD_BITS));
  localparam logic signed [ZACC_W-1:0] RND_HALF = ZACC_W'(64'sd1 << (RND_SH - 1));

  step_t  pc, pc_next;
  uword_t uw;
  logic   accept, skip, done;

  logic [ITER_W-1:0] iter;

  logic                        mode_r;
  logic signed [COORD_W-1:0]   px_r, py_r, sl_r;
  logic signed [CORDIC_W-1:0]  x, y, xs, ys, x_init, y_init;
  logic signed [ZACC_W-1:0]    z, atan_i;
  logic signed [ANGLE_W-1:0]   a, prev, skip_angle, a_round, mag_c, r;
  logic signed [TMP_W-1:0]     tmp;
  logic signed [PROD_W-1:0]    prod, prod_next;
  logic signed [ACC_W-1:0]     acc;

  // operand prep
  logic signed [COORD_W:0]     pxe, pye, pxn, pyn, sle;
  logic [COORD_W:0]            sl_mag;
  logic                        slope_ok;

  // rounding
  logic signed [ZACC_W-1:0]    zabs, rnd;

  // gain products
  logic signed [ANGLE_W:0]     a_sum, a_dif;
  logic [GAIN_W-1:0]           mul_a;
  logic signed [TMP_W-1:0]     mul_b;

  // turn
  logic [ACC_W-1:0]            acc_abs, tmag;
  logic signed [TURN_W-1:0]    turn;

  assign uw       = ucode(pc);
  assign in_ready = (uw.cond == CD_WAIT_IN) && !rst;
  assign accept   = in_valid && in_ready;
  assign done     = (uw.op == OP_OUT) && out_free;

  always_comb begin
    pxe = {px_r[COORD_W-1], px_r};
    pye = {py_r[COORD_W-1], py_r};
    // negative forward distance flips both axes
    pxn = py_r[COORD_W-1] ? -pxe : pxe;
    pyn = py_r[COORD_W-1] ? -pye : pye;
    sle = {sl_r[COORD_W-1], sl_r};
    sl_mag = sle[COORD_W] ? (COORD_W + 1)'(-sle) : (COORD_W + 1)'(sle);
    slope_ok = (sl_mag != '0) && (sl_mag < (COORD_W + 1)'(cfg.slope_limit));
    skip = mode_r ? !slope_ok : (py_r == '0);
    if (mode_r) begin
      skip_angle = prev;
      x_init     = SLOPE_ONE_X;
      y_init     = $signed(CORDIC_W'(sl_mag)) <<< GUARD_BITS;
    end else begin
      skip_angle = (px_r > 0) ? NINETY : ((px_r < 0) ? -NINETY : '0);
      x_init     = CORDIC_W'(pyn) <<< GUARD_BITS;
      y_init     = CORDIC_W'(pxn) <<< GUARD_BITS;
    end
  end

  always_comb begin
    xs     = x >>> iter;
    ys     = y >>> iter;
    atan_i = atan_q24(TBL_IDX_W'(iter));
  end

  // round half away from zero, clamp to +/-90
  always_comb begin
    zabs    = z[ZACC_W-1] ? -z : z;
    rnd     = (zabs + RND_HALF) >>> RND_SH;
    mag_c   = (rnd > ZACC_W'(NINETY)) ? NINETY : ANGLE_W'(rnd);
    r       = z[ZACC_W-1] ? -mag_c : mag_c;
    a_round = mode_r ? (NINETY - r) : r;
  end

  always_comb begin
    a_sum = (ANGLE_W + 1)'(a) + (ANGLE_W + 1)'(prev);
    a_dif = (ANGLE_W + 1)'(a) - (ANGLE_W + 1)'(prev);
    case (uw.op)
      OP_MUL_SPD: begin
        mul_a = GAIN_W'(cfg.vehicle_speed);
        mul_b = TMP_W'(a_sum);
      end
      OP_MUL_P: begin
        mul_a = cfg.gain_p;
        mul_b = TMP_W'(a);
      end
      OP_MUL_I: begin
        mul_a = cfg.gain_i;
        mul_b = tmp;
      end
      OP_MUL_D: begin
        mul_a = cfg.gain_d;
        mul_b = TMP_W'(a_dif);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_next = $signed({1'b0, mul_a}) * mul_b;
  end

  // truncate toward zero, saturate
  always_comb begin
    acc_abs = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    tmag    = acc_abs >> TURN_SH;
    if (acc[ACC_W-1]) begin
      turn = (tmag >= ACC_W'(512)) ? TURN_MIN : -TURN_W'(tmag);
    end else begin
      turn = (tmag > ACC_W'(511)) ? TURN_MAX : TURN_W'(tmag);
    end
  end

  always_comb begin
    case (uw.cond)
      CD_NEXT:     pc_next = pc + 4'd1;
      CD_WAIT_IN:  pc_next = accept ? pc + 4'd1 : pc;
      CD_SKIP:     pc_next = skip ? uw.target : pc + 4'd1;
      CD_LOOP:     pc_next = (iter == ITER_LAST) ? pc + 4'd1 : uw.target;
      CD_WAIT_OUT: pc_next = out_free ? uw.target : pc;
      CD_JUMP:     pc_next = uw.target;
      default:     pc_next = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= STEP_IDLE;
      iter <= '0;
      prev <= '0;
    end else begin
      pc <= pc_next;
      if (uw.op == OP_PREP) begin
        iter <= '0;
      end else if (uw.op == OP_ITER) begin
        iter <= iter + 1'b1;
      end
      if (done) begin
        prev <= a;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
    case (uw.op)
      OP_LOAD: begin
        if (accept) begin
          mode_r <= in_mode;
          px_r   <= in_px;
          py_r   <= in_py;
          sl_r   <= in_slope;
        end
      end
      OP_PREP: begin
        x <= x_init;
        y <= y_init;
        z <= '0;
        if (skip) begin
          a <= skip_angle;
        end
      end
      OP_ITER: begin
        if (y > 0) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + atan_i;
        end else if (y < 0) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - atan_i;
        end
      end
      OP_ROUND:  a <= a_round;
      OP_MUL_P:  tmp <= TMP_W'(prod);
      OP_MUL_I:  acc <= ACC_W'(prod);
      OP_MUL_D:  acc <= acc + ACC_W'(prod);
      OP_ACC:    acc <= acc + ACC_W'(prod);
      default: ;
    endcase
  end

  assign res.done          = done;
  assign res.turn_command  = turn;
  assign res.heading_angle = a;

  `ASSERT_NEXT(a_accept_to_prep, clk, rst, accept, pc == STEP_PREP)
  `ASSERT_NEXT(a_done_to_idle, clk, rst, done, in_ready)
  `ASSERT_IMPL(a_angle_range, clk, rst, done, (a <= NINETY) && (a >= -NINETY))
  `ASSERT_IMPL(a_round_after_loop, clk, rst, uw.op == OP_ROUND,
    $past(uw.op == OP_ITER && iter == ITER_LAST))

endmodule

// ===== hdl/line_steering_angle_controller_core.sv =====
// Heading-angle steering controller. Each input transaction gives one output
// transaction: heading_angle in degrees (signed, 8 fraction bits) and an integer
// turn_command from the P/I/D-style gain sum. Point mode takes atan(x/y), slope
// mode takes 90 - atan(|slope|) and keeps the previous angle for a zero slope or
// one at or beyond slope_limit. A microcoded sequencer runs one CORDIC iteration
// per cycle and then the gain products on one shared multiplier, skipping the
// iterations when no arctangent is needed. One item is in work at a time, and the
// next one is taken while the previous result waits for m_tready.
// Gains and limits are to be written over APB only while the block is idle; the
// block itself does not enforce this.
module line_steering_angle_controller_core #(
  parameter int CORDIC_STEPS = lsac_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // stream in
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [47:0]                         s_tdata,   // point_x, point_y, line_slope
  input  logic [0:0]                          s_tuser,   // mode
  // stream out
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [31:0]                         m_tdata,   // turn_command, heading_angle, pad
  // APB
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lsac_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [lsac_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [lsac_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import lsac_pkg::*;

  cfg_t cfg;
  res_t res;
  logic [REG_IDX_W-1:0] reg_idx;
  logic out_free;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_GAIN_P:      cfg.gain_p        <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:      cfg.gain_i        <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:      cfg.gain_d        <= pwdata[GAIN_W-1:0];
        REG_SPEED:       cfg.vehicle_speed <= pwdata[SPEED_W-1:0];
        REG_SLOPE_LIMIT: cfg.slope_limit   <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GAIN_P:      prdata = APB_DATA_W'(cfg.gain_p);
      REG_GAIN_I:      prdata = APB_DATA_W'(cfg.gain_i);
      REG_GAIN_D:      prdata = APB_DATA_W'(cfg.gain_d);
      REG_SPEED:       prdata = APB_DATA_W'(cfg.vehicle_speed);
      REG_SLOPE_LIMIT: prdata = APB_DATA_W'(cfg.slope_limit);
      default:         prdata = '0;
    endcase
  end

  assign out_free = !m_tvalid || m_tready;

  lsac_engine #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_mode  (s_tuser[0]),
    .in_px    (s_tdata[15:0]),
    .in_py    (s_tdata[31:16]),
    .in_slope (s_tdata[47:32]),
    .out_free (out_free),
    .res      (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.done) begin
      m_tdata <= {5'b0, res.heading_angle, res.turn_command};
    end
  end

endmodule
